@@ src/pfs_pkg.sv @@
// Shared types and constants for the priority FIFO scheduler.
// No dependencies; compiled first.
package pfs_pkg;

   localparam int OP_W   = 2;
   localparam int ID_W   = 6;
   localparam int PRIO_W = 5;

   localparam int DEF_NUM_LEVELS  = 32;
   localparam int DEF_NUM_THREADS = 64;

   typedef enum logic [OP_W-1:0] {
      OP_INIT   = 2'd0,
      OP_ADD    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_SWITCH = 2'd3
   } pfs_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UL_RD,
      S_UL_LNK,
      S_UL_WR,
      S_INS,
      S_INS_WR,
      S_SW_PICK,
      S_SW_HEAD,
      S_DONE,
      S_RSP
   } pfs_state_type;

endpackage

@@ src/pfs_chan_if.sv @@
// Valid/ready channel interfaces for scheduler requests and responses.
// Depends on pfs_pkg for field widths.
interface pfs_req_if;
   logic                       valid;
   logic                       ready;
   logic [pfs_pkg::OP_W-1:0]   op;
   logic [pfs_pkg::ID_W-1:0]   thread_id;
   logic [pfs_pkg::PRIO_W-1:0] priority_req;
   logic [pfs_pkg::ID_W-1:0]   idle_id;
   logic [pfs_pkg::PRIO_W-1:0] idle_priority;
   logic                       current_runnable;

   modport source (output valid, op, thread_id, priority_req, idle_id, idle_priority,
                   current_runnable, input ready);
   modport sink (input valid, op, thread_id, priority_req, idle_id, idle_priority,
                 current_runnable, output ready);
endinterface

interface pfs_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       flag;
   logic [pfs_pkg::ID_W-1:0]   running_id;
   logic [pfs_pkg::PRIO_W-1:0] running_priority;
   logic                       none_ready;

   modport source (output valid, flag, running_id, running_priority, none_ready,
                   input ready);
   modport sink (input valid, flag, running_id, running_priority, none_ready,
                 output ready);
endinterface

@@ src/priority_fifo_scheduler.sv @@
// Priority FIFO scheduler: per-level thread FIFOs kept as linked lists in memory.
// Depends on pfs_pkg and the pfs_req_if / pfs_rsp_if interfaces.
// A switch that requeues the current thread and dequeues the next is the longest
//   transaction; an unlink reads the thread's links, then its level's head and tail,
//   then writes them back, and an insert reads then writes. One transaction in flight.
// Reset clears control state, queued and nonempty bits; link memories are not cleared.
module priority_fifo_scheduler #(
   parameter int NUM_LEVELS  = pfs_pkg::DEF_NUM_LEVELS,
   parameter int NUM_THREADS = pfs_pkg::DEF_NUM_THREADS
) (
   input logic       clock,
   input logic       reset,
   pfs_req_if.sink   req_chan,
   pfs_rsp_if.source rsp_chan
);

   localparam int LW     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int TW     = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
   localparam int ID_CNT = 2 ** pfs_pkg::ID_W;

   function automatic logic [ID_CNT*TW-1:0] mod_tab();
      logic [ID_CNT*TW-1:0] tab;
      int r;
      tab = '0;
      r   = 0;
      for (int i = 0; i < ID_CNT; i++) begin
         tab[i*TW +: TW] = TW'(r);
         r = (r == NUM_THREADS - 1) ? 0 : r + 1;
      end
      return tab;
   endfunction

   localparam logic [ID_CNT*TW-1:0] MOD_TAB = mod_tab();

   // memories
   logic [TW-1:0] next_mem [NUM_THREADS];
   logic [TW-1:0] prev_mem [NUM_THREADS];
   logic [LW-1:0] qlvl_mem [NUM_THREADS];
   logic [TW-1:0] head_mem [NUM_LEVELS];
   logic [TW-1:0] tail_mem [NUM_LEVELS];

   logic [TW-1:0] next_q, prev_q, head_q, tail_q;
   logic [LW-1:0] qlvl_q;
   logic [LW-1:0] lt_raddr;

   logic          nx_we, pv_we, hd_we, tl_we, ql_we;
   logic [TW-1:0] nx_wa, nx_wd, pv_wa, pv_wd, hd_wd, tl_wd;
   logic [LW-1:0] hd_wa, tl_wa;

   pfs_pkg::pfs_state_type state_ff, state_in;

   logic [TW-1:0]          t_ff, t_in, cur_ff, cur_in;
   logic [LW-1:0]          lv_ff, lv_in, h_ff, h_in, cur_lvl_ff, cur_lvl_in;
   logic                   at_head_ff, at_head_in, ins_pend_ff, ins_pend_in;
   logic                   sw_pick_ff, sw_pick_in, sw_final_ff, sw_final_in;
   logic                   flag_ff, flag_in, zombie_ff, zombie_in;
   logic [NUM_LEVELS-1:0]  nonempty_ff, nonempty_in;
   logic [NUM_THREADS-1:0] queued_ff, queued_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_flag_ff, rsp_flag_in, rsp_none_ff, rsp_none_in;
   logic [TW-1:0]          rsp_id_ff, rsp_id_in;
   logic [LW-1:0]          rsp_lvl_ff, rsp_lvl_in;

   logic          accept, runnable, rsp_load;
   logic [TW-1:0] req_tid, req_iid;
   logic [LW-1:0] req_lvl, req_ilvl, low_idx;
   logic          low_any;
   pfs_pkg::pfs_op_type req_op;

   assign req_chan.ready = (state_ff == pfs_pkg::S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign req_op         = pfs_pkg::pfs_op_type'(req_chan.op);
   assign req_tid        = MOD_TAB[req_chan.thread_id*TW +: TW];
   assign req_iid        = MOD_TAB[req_chan.idle_id*TW +: TW];
   assign req_lvl        = (int'(req_chan.priority_req) >= NUM_LEVELS) ?
                           LW'(NUM_LEVELS - 1) : LW'(req_chan.priority_req);
   assign req_ilvl       = (int'(req_chan.idle_priority) >= NUM_LEVELS) ?
                           LW'(NUM_LEVELS - 1) : LW'(req_chan.idle_priority);
   assign runnable       = req_chan.current_runnable && !zombie_ff;
   assign rsp_load       = !rsp_valid_ff || rsp_chan.ready;
   assign low_any        = |nonempty_ff;

   always_comb begin
      low_idx = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            low_idx = LW'(i);
         end
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.flag             = rsp_flag_ff;
   assign rsp_chan.running_id       = pfs_pkg::ID_W'(rsp_id_ff);
   assign rsp_chan.running_priority = pfs_pkg::PRIO_W'(rsp_lvl_ff);
   assign rsp_chan.none_ready       = rsp_none_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfs_pkg::S_IDLE: begin
            if (accept) begin
               case (req_op)
                  pfs_pkg::OP_REMOVE:
                     state_in = (req_tid == cur_ff) ? pfs_pkg::S_DONE : pfs_pkg::S_UL_RD;
                  pfs_pkg::OP_SWITCH: begin
                     if (!runnable) begin
                        state_in = pfs_pkg::S_SW_PICK;
                     end else begin
                        state_in = low_any ? pfs_pkg::S_UL_RD : pfs_pkg::S_DONE;
                     end
                  end
                  default: state_in = pfs_pkg::S_UL_RD;
               endcase
            end
         end
         pfs_pkg::S_UL_RD: begin
            if (queued_ff[t_ff]) begin
               state_in = pfs_pkg::S_UL_LNK;
            end else begin
               state_in = ins_pend_ff ? pfs_pkg::S_INS : pfs_pkg::S_DONE;
            end
         end
         pfs_pkg::S_UL_LNK: state_in = pfs_pkg::S_UL_WR;
         pfs_pkg::S_UL_WR:  state_in = ins_pend_ff ? pfs_pkg::S_INS : pfs_pkg::S_DONE;
         pfs_pkg::S_INS: begin
            if (nonempty_ff[lv_ff]) begin
               state_in = pfs_pkg::S_INS_WR;
            end else begin
               state_in = sw_pick_ff ? pfs_pkg::S_SW_PICK : pfs_pkg::S_DONE;
            end
         end
         pfs_pkg::S_INS_WR:  state_in = sw_pick_ff ? pfs_pkg::S_SW_PICK : pfs_pkg::S_DONE;
         pfs_pkg::S_SW_PICK: state_in = low_any ? pfs_pkg::S_SW_HEAD : pfs_pkg::S_DONE;
         pfs_pkg::S_SW_HEAD: state_in = pfs_pkg::S_UL_RD;
         pfs_pkg::S_DONE:    state_in = pfs_pkg::S_RSP;
         pfs_pkg::S_RSP:     state_in = rsp_load ? pfs_pkg::S_IDLE : pfs_pkg::S_RSP;
         default:            state_in = pfs_pkg::S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      t_in = t_ff;  lv_in = lv_ff;  h_in = h_ff;
      at_head_in = at_head_ff;  ins_pend_in = ins_pend_ff;
      sw_pick_in = sw_pick_ff;  sw_final_in = sw_final_ff;
      flag_in = flag_ff;  zombie_in = zombie_ff;
      cur_in = cur_ff;  cur_lvl_in = cur_lvl_ff;
      nonempty_in = nonempty_ff;  queued_in = queued_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_flag_in = rsp_flag_ff;  rsp_none_in = rsp_none_ff;
      rsp_id_in = rsp_id_ff;  rsp_lvl_in = rsp_lvl_ff;
      nx_we = 1'b0;  nx_wa = '0;  nx_wd = '0;
      pv_we = 1'b0;  pv_wa = '0;  pv_wd = '0;
      hd_we = 1'b0;  hd_wa = '0;  hd_wd = '0;
      tl_we = 1'b0;  tl_wa = '0;  tl_wd = '0;
      ql_we = 1'b0;
      lt_raddr = lv_ff;
      case (state_ff)
         pfs_pkg::S_IDLE: begin
            if (accept) begin
               sw_pick_in  = 1'b0;
               sw_final_in = 1'b0;
               at_head_in  = 1'b0;
               flag_in     = 1'b0;
               t_in        = req_tid;
               lv_in       = req_lvl;
               case (req_op)
                  pfs_pkg::OP_INIT: begin
                     nonempty_in = '0;
                     queued_in   = '0;
                     cur_in      = req_tid;
                     cur_lvl_in  = req_lvl;
                     zombie_in   = 1'b0;
                     t_in        = req_iid;
                     lv_in       = req_ilvl;
                     ins_pend_in = 1'b1;
                     flag_in     = req_ilvl < req_lvl;
                  end
                  pfs_pkg::OP_ADD: begin
                     ins_pend_in = 1'b1;
                     flag_in     = req_lvl < cur_lvl_ff;
                  end
                  pfs_pkg::OP_REMOVE: begin
                     ins_pend_in = 1'b0;
                     if (req_tid == cur_ff) begin
                        zombie_in = 1'b1;
                        flag_in   = 1'b1;
                     end
                  end
                  default: begin
                     t_in        = cur_ff;
                     lv_in       = cur_lvl_ff;
                     at_head_in  = cur_lvl_ff > low_idx;
                     ins_pend_in = runnable;
                     sw_pick_in  = 1'b1;
                  end
               endcase
            end
         end
         pfs_pkg::S_UL_LNK: lt_raddr = qlvl_q;
         pfs_pkg::S_UL_WR: begin
            queued_in[t_ff] = 1'b0;
            if (head_q == t_ff && tail_q == t_ff) begin
               nonempty_in[qlvl_q] = 1'b0;
            end else if (head_q == t_ff) begin
               hd_we = 1'b1;  hd_wa = qlvl_q;  hd_wd = next_q;
            end else if (tail_q == t_ff) begin
               tl_we = 1'b1;  tl_wa = qlvl_q;  tl_wd = prev_q;
               nx_we = 1'b1;  nx_wa = prev_q;  nx_wd = '0;
            end else begin
               nx_we = 1'b1;  nx_wa = prev_q;  nx_wd = next_q;
               pv_we = 1'b1;  pv_wa = next_q;  pv_wd = prev_q;
            end
         end
         pfs_pkg::S_INS: begin
            if (!nonempty_ff[lv_ff]) begin
               hd_we = 1'b1;  hd_wa = lv_ff;  hd_wd = t_ff;
               tl_we = 1'b1;  tl_wa = lv_ff;  tl_wd = t_ff;
               nonempty_in[lv_ff] = 1'b1;
               queued_in[t_ff]    = 1'b1;
               ql_we = 1'b1;
            end
         end
         pfs_pkg::S_INS_WR: begin
            queued_in[t_ff] = 1'b1;
            ql_we = 1'b1;
            if (at_head_ff) begin
               nx_we = 1'b1;  nx_wa = t_ff;    nx_wd = head_q;
               pv_we = 1'b1;  pv_wa = head_q;  pv_wd = t_ff;
               hd_we = 1'b1;  hd_wa = lv_ff;   hd_wd = t_ff;
            end else begin
               nx_we = 1'b1;  nx_wa = tail_q;  nx_wd = t_ff;
               pv_we = 1'b1;  pv_wa = t_ff;    pv_wd = tail_q;
               tl_we = 1'b1;  tl_wa = lv_ff;   tl_wd = t_ff;
            end
         end
         pfs_pkg::S_SW_PICK: begin
            lt_raddr = low_idx;
            h_in     = low_idx;
         end
         pfs_pkg::S_SW_HEAD: begin
            t_in        = head_q;
            ins_pend_in = 1'b0;
            sw_pick_in  = 1'b0;
            sw_final_in = 1'b1;
         end
         pfs_pkg::S_DONE: begin
            if (sw_final_ff) begin
               cur_in     = t_ff;
               cur_lvl_in = h_ff;
               zombie_in  = 1'b0;
            end
         end
         pfs_pkg::S_RSP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = flag_ff;
               rsp_id_in    = cur_ff;
               rsp_lvl_in   = cur_lvl_ff;
               rsp_none_in  = !low_any;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      next_q <= next_mem[t_ff];
      prev_q <= prev_mem[t_ff];
      qlvl_q <= qlvl_mem[t_ff];
      head_q <= head_mem[lt_raddr];
      tail_q <= tail_mem[lt_raddr];
      if (nx_we) next_mem[nx_wa] <= nx_wd;
      if (pv_we) prev_mem[pv_wa] <= pv_wd;
      if (ql_we) qlvl_mem[t_ff] <= lv_ff;
      if (hd_we) head_mem[hd_wa] <= hd_wd;
      if (tl_we) tail_mem[tl_wa] <= tl_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfs_pkg::S_IDLE;
         cur_ff       <= '0;
         cur_lvl_ff   <= '0;
         zombie_ff    <= 1'b0;
         nonempty_ff  <= '0;
         queued_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         ins_pend_ff  <= 1'b0;
         sw_pick_ff   <= 1'b0;
         sw_final_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         cur_lvl_ff   <= cur_lvl_in;
         zombie_ff    <= zombie_in;
         nonempty_ff  <= nonempty_in;
         queued_ff    <= queued_in;
         rsp_valid_ff <= rsp_valid_in;
         ins_pend_ff  <= ins_pend_in;
         sw_pick_ff   <= sw_pick_in;
         sw_final_ff  <= sw_final_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      lv_ff       <= lv_in;
      h_ff        <= h_in;
      at_head_ff  <= at_head_in;
      flag_ff     <= flag_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_none_ff <= rsp_none_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_lvl_ff  <= rsp_lvl_in;
   end

endmodule
